/* hw/rtl/dtw_pkg.sv */
package dtw_pkg;

    // Function codes of an input word.
    localparam logic [1:0] FUNC_WR_NODE  = 2'd0;
    localparam logic [1:0] FUNC_WR_FEAT  = 2'd1;
    localparam logic [1:0] FUNC_TRAVERSE = 2'd2;

    // Compare modes of a node.
    localparam logic [2:0] MODE_LEQ  = 3'd0;
    localparam logic [2:0] MODE_LT   = 3'd1;
    localparam logic [2:0] MODE_GTE  = 3'd2;
    localparam logic [2:0] MODE_GT   = 3'd3;
    localparam logic [2:0] MODE_EQ   = 3'd4;
    localparam logic [2:0] MODE_NEQ  = 3'd5;
    localparam logic [2:0] MODE_LEAF = 3'd6;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ABSENT    = 2'd1;
    localparam logic [1:0] ST_FEAT_OOR  = 2'd2;
    localparam logic [1:0] ST_STEP_OVER = 2'd3;

    localparam int ACTIVE_W = 7;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd64;

    typedef struct packed {
        logic [1:0]         func;
        logic [3:0]         tree_id;
        logic [7:0]         node_id;
        logic [2:0]         node_mode;
        logic [5:0]         split_feature;
        logic signed [31:0] threshold;
        logic [7:0]         true_next;
        logic [7:0]         false_next;
        logic               missing_goes_true;
        logic [5:0]         feature_index;
        logic signed [31:0] feature_sample;
        logic               feature_missing;
    } dtw_in_t;

    typedef struct packed {
        logic [7:0] leaf_node;
        logic [1:0] status;
    } dtw_out_t;

    // One node table entry; the present flag lives alongside the payload.
    typedef struct packed {
        logic               present;
        logic [2:0]         mode;
        logic [5:0]         feat;
        logic signed [31:0] thr;
        logic [7:0]         tnext;
        logic [7:0]         fnext;
        logic               miss_true;
    } dtw_node_t;

    typedef struct packed {
        logic               missing;
        logic signed [31:0] value;
    } dtw_feat_t;

endpackage

/* hw/rtl/decision_tree_walk_core.sv */
// Channel   Signals                         Direction  Transfer
// command   start, busy, item               in         start high while busy is low
// result    done, result                    out        done high for one cycle, no stall
// config    cfg_we, cfg_data                in         cfg_we high, taken at once
//
// Node and feature writes produce no result word.
// A traversal takes each branch node through node read, evaluate with feature read
// and compare, and the node that ends it through node read and evaluate; at the step
// limit the walk ends in the node read after its last branch; busy stays high throughout.
// The result word shows in the first cycle with busy low again.
// After reset all 2**(TW+NW) node table entries (4096 at the defaults) are swept once
// to clear the present flags, one entry per cycle; busy stays high during the sweep.
// The result word is shown for exactly one cycle; the receiver cannot stall it.
module decision_tree_walk_core #(
    parameter int TREES          = 16,
    parameter int NODES_PER_TREE = 256,
    parameter int FEATURES       = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  dtw_pkg::dtw_in_t           item,
    output logic                       done,
    output dtw_pkg::dtw_out_t          result,
    input  logic                       cfg_we,
    input  logic [dtw_pkg::ACTIVE_W-1:0] cfg_data
);
    import dtw_pkg::*;

    // Address widths of the node table (tree bits over node bits) and of
    // the feature row.
    localparam int TW    = (TREES > 1) ? $clog2(TREES) : 1;
    localparam int NW    = $clog2(NODES_PER_TREE);
    localparam int AW    = TW + NW;
    localparam int DEPTH = 1 << AW;
    localparam int FW    = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int FD    = 1 << FW;
    // The step counter must be able to hold the node count itself.
    localparam int SW    = $clog2(NODES_PER_TREE + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_NODE_RD,
        S_NODE_EV,
        S_CMP
    } state_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         clr_reg, clr_next;
    logic [TW-1:0]         tree_reg, tree_next;
    logic [7:0]            cur_reg, cur_next;
    logic [SW-1:0]         steps_reg, steps_next;
    logic [ACTIVE_W-1:0]   active_reg, active_next;
    logic                  done_reg, done_next;
    dtw_out_t              result_reg, result_next;

    dtw_node_t             node_mem [DEPTH];
    dtw_feat_t             feat_mem [FD];
    dtw_node_t             node_rd_reg;
    dtw_feat_t             feat_rd_reg;

    logic                  node_we;
    logic [AW-1:0]         node_wr_addr;
    dtw_node_t             node_wr_data;
    logic                  node_rd_en;
    logic [AW-1:0]         node_rd_addr;
    logic                  feat_we;
    logic                  feat_rd_en;

    // Widened copies of the narrow fields so range checks and address slices
    // work for every parameter value.
    logic [8:0]            tree_ext;
    logic [16:0]           node_ext;
    logic [16:0]           cur_ext;
    logic [12:0]           fidx_ext;
    logic [12:0]           split_ext;
    logic                  accept;
    logic                  tree_ok;
    logic                  node_ok;
    logic                  fidx_ok;
    logic                  split_bad;
    logic                  val_lt;
    logic                  val_eq;
    logic                  cmp_hold;
    logic                  go_true;

    assign tree_ext  = {5'd0, item.tree_id};
    assign node_ext  = {9'd0, item.node_id};
    assign cur_ext   = {9'd0, cur_reg};
    assign fidx_ext  = {7'd0, item.feature_index};
    assign split_ext = {7'd0, node_rd_reg.feat};

    assign accept  = start && (state_reg == S_IDLE);
    assign tree_ok = tree_ext < 9'(TREES);
    assign node_ok = node_ext < 17'(NODES_PER_TREE);
    assign fidx_ok = fidx_ext < 13'(FEATURES);

    assign split_bad = ({1'b0, node_rd_reg.feat} >= active_reg)
                    || (split_ext >= 13'(FEATURES));

    // Shared signed compare unit; the mode picks the relation it reports.
    assign val_lt = feat_rd_reg.value < node_rd_reg.thr;
    assign val_eq = feat_rd_reg.value == node_rd_reg.thr;

    always_comb
    begin
        unique case (node_rd_reg.mode)
            MODE_LEQ: cmp_hold = val_lt || val_eq;
            MODE_LT:  cmp_hold = val_lt;
            MODE_GTE: cmp_hold = !val_lt;
            MODE_GT:  cmp_hold = !val_lt && !val_eq;
            MODE_EQ:  cmp_hold = val_eq;
            default:  cmp_hold = !val_eq;
        endcase
    end

    // A missing feature ignores the mode and takes the stored direction.
    assign go_true = feat_rd_reg.missing ? node_rd_reg.miss_true : cmp_hold;

    // Node table write port: the clearing sweep or a node write word.
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            node_we      = 1'b1;
            node_wr_addr = clr_reg;
            node_wr_data = '0;
        end
        else
        begin
            node_we      = accept && (item.func == FUNC_WR_NODE) && tree_ok && node_ok;
            node_wr_addr = {tree_ext[TW-1:0], node_ext[NW-1:0]};
            node_wr_data.present   = 1'b1;
            node_wr_data.mode      = item.node_mode;
            node_wr_data.feat      = item.split_feature;
            node_wr_data.thr       = item.threshold;
            node_wr_data.tnext     = item.true_next;
            node_wr_data.fnext     = item.false_next;
            node_wr_data.miss_true = item.missing_goes_true;
        end
    end

    assign feat_we      = accept && (item.func == FUNC_WR_FEAT) && fidx_ok;
    assign node_rd_addr = {tree_reg, cur_ext[NW-1:0]};

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_wr_addr] <= node_wr_data;
        end
        if (node_rd_en)
        begin
            node_rd_reg <= node_mem[node_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (feat_we)
        begin
            feat_mem[fidx_ext[FW-1:0]] <= {item.feature_missing, item.feature_sample};
        end
        if (feat_rd_en)
        begin
            feat_rd_reg <= feat_mem[split_ext[FW-1:0]];
        end
    end

    // Sequencer: clearing sweep, then one node per read, evaluate, compare pass.
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        tree_next   = tree_reg;
        cur_next    = cur_reg;
        steps_next  = steps_reg;
        active_next = cfg_we ? cfg_data : active_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        node_rd_en  = 1'b0;
        feat_rd_en  = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept && (item.func == FUNC_TRAVERSE))
                begin
                    if (!tree_ok)
                    begin
                        done_next   = 1'b1;
                        result_next = '{leaf_node: 8'd0, status: ST_ABSENT};
                    end
                    else
                    begin
                        tree_next  = tree_ext[TW-1:0];
                        cur_next   = 8'd0;
                        steps_next = '0;
                        state_next = S_NODE_RD;
                    end
                end
            end
            S_NODE_RD:
            begin
                if (steps_reg == SW'(NODES_PER_TREE))
                begin
                    done_next   = 1'b1;
                    result_next = '{leaf_node: 8'd0, status: ST_STEP_OVER};
                    state_next  = S_IDLE;
                end
                else if (cur_ext >= 17'(NODES_PER_TREE))
                begin
                    done_next   = 1'b1;
                    result_next = '{leaf_node: 8'd0, status: ST_ABSENT};
                    state_next  = S_IDLE;
                end
                else
                begin
                    node_rd_en = 1'b1;
                    state_next = S_NODE_EV;
                end
            end
            S_NODE_EV:
            begin
                priority if (!node_rd_reg.present)
                begin
                    done_next   = 1'b1;
                    result_next = '{leaf_node: 8'd0, status: ST_ABSENT};
                    state_next  = S_IDLE;
                end
                else if (node_rd_reg.mode >= MODE_LEAF)
                begin
                    // The unused mode code also ends the walk as a leaf.
                    done_next   = 1'b1;
                    result_next = '{leaf_node: cur_reg, status: ST_OK};
                    state_next  = S_IDLE;
                end
                else if (split_bad)
                begin
                    done_next   = 1'b1;
                    result_next = '{leaf_node: 8'd0, status: ST_FEAT_OOR};
                    state_next  = S_IDLE;
                end
                else
                begin
                    feat_rd_en = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cur_next   = go_true ? node_rd_reg.tnext : node_rd_reg.fnext;
                steps_next = steps_reg + 1'b1;
                state_next = S_NODE_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            tree_reg   <= '0;
            cur_reg    <= '0;
            steps_reg  <= '0;
            active_reg <= ACTIVE_RESET;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            tree_reg   <= tree_next;
            cur_reg    <= cur_next;
            steps_reg  <= steps_next;
            active_reg <= active_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
